[hdl/tsrq_pkg.sv]
// ----------------------------------------------------------------------------
// tsrq_pkg
// Shared types, sizes and codes of the tile map store with region query.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrq_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int CODE_BITS   = 16;

	localparam int GRID_SIZE = MAX_COLUMNS * MAX_ROWS;
	localparam int GRID_W    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
	localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// Divider sizes: dividends reach x + width + 16 * tile - 1 < 2^21.
	localparam int DVD_W = 21;
	localparam int DVS_W = 12;
	localparam int CNT_W = $clog2(DVD_W + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 2'd3;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	typedef logic [CODE_BITS-1:0] code_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [19:0] x_pos;
		logic signed [19:0] y_pos;
		logic [18:0]        span_width;
		logic [18:0]        span_height;
		logic [15:0]        write_code;
	} in_word_t;

	typedef struct packed {
		logic        status;
		logic [15:0] tile_code;
	} out_word_t;

	typedef enum logic [2:0] {
		DIV_LEFT,
		DIV_TOP,
		DIV_RIGHT,
		DIV_BOTTOM,
		DIV_COLS,
		DIV_ROWS
	} div_op_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_BAD,
		RES_DATA
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_op_t  div_op;
		logic     clr_wr;
		logic     mem_wr;
		logic     mem_rd;
		logic     scan_init;
		logic     scan_rd;
		logic     scan_step;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       neg;
		logic       pt_bad;
		logic       q_bad;
		logic       q_empty;
		logic       div_done;
		logic       clr_last;
		logic       rd_nz;
		logic       scan_last;
	} stat_t;

	function automatic logic [GRID_W-1:0] grid_addr(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row);
		grid_addr = GRID_W'(col) * GRID_W'(MAX_ROWS) + GRID_W'(row);
	endfunction

endpackage

`default_nettype wire

[hdl/tsrq_div.sv]
// ----------------------------------------------------------------------------
// tsrq_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrq_div
	import tsrq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

[hdl/tsrq_dp.sv]
// ----------------------------------------------------------------------------
// tsrq_dp
// Datapath: configuration, tile store, divider, scan counters and result.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrq_dp
	import tsrq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire in_word_t              in_word,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	output out_word_t                  out_word
);

	logic [7:0]  tw_q, th_q;
	logic [13:0] mw_q, mh_q;
	in_word_t    in_q;

	logic [DVD_W-1:0] qx_q, qy_q, qr_q, qb_q, qc_q, qrows_q;
	div_op_t          op_q;
	logic [DVD_W-1:0] dividend, quotient;
	logic [DVS_W-1:0] divisor;
	logic [DVS_W-1:0] dw, dh;
	logic             div_done;

	code_t            mem_q [GRID_SIZE];
	code_t            rdata_q;
	logic [GRID_W-1:0] clr_q;
	logic [COL_W-1:0] i_q;
	logic [ROW_W-1:0] j_q;
	logic [GRID_W-1:0] pt_addr, sc_addr, waddr, raddr;
	logic             mem_we;
	code_t            wdata;

	out_word_t        res_q, out_q;
	logic [DVD_W-1:0] cols_cap, rows_cap;
	logic             last_row, last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= 8'd16;
			th_q <= 8'd16;
			mw_q <= 14'd1024;
			mh_q <= 14'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILE_WIDTH:  tw_q <= cfg_data[7:0];
				REG_TILE_HEIGHT: th_q <= cfg_data[7:0];
				REG_MAP_WIDTH:   mw_q <= cfg_data;
				REG_MAP_HEIGHT:  mh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A tile size of zero behaves as one.
	assign dw = {((tw_q == 8'd0) ? 8'd1 : tw_q), 4'b0};
	assign dh = {((th_q == 8'd0) ? 8'd1 : th_q), 4'b0};

	always_comb begin
		dividend = DVD_W'(in_q.x_pos[18:0]);
		divisor  = dw;
		case (cmd.div_op)
			DIV_LEFT: begin
				dividend = DVD_W'(in_q.x_pos[18:0]);
				divisor  = dw;
			end
			DIV_TOP: begin
				dividend = DVD_W'(in_q.y_pos[18:0]);
				divisor  = dh;
			end
			DIV_RIGHT: begin
				dividend = DVD_W'(in_q.x_pos[18:0]) + DVD_W'(in_q.span_width)
					+ DVD_W'(dw) - DVD_W'(1);
				divisor  = dw;
			end
			DIV_BOTTOM: begin
				dividend = DVD_W'(in_q.y_pos[18:0]) + DVD_W'(in_q.span_height)
					+ DVD_W'(dh) - DVD_W'(1);
				divisor  = dh;
			end
			DIV_COLS: begin
				dividend = DVD_W'({mw_q, 4'b0});
				divisor  = dw;
			end
			DIV_ROWS: begin
				dividend = DVD_W'({mh_q, 4'b0});
				divisor  = dh;
			end
			default: ;
		endcase
	end

	tsrq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_word;
		end
		if (cmd.div_start) begin
			op_q <= cmd.div_op;
		end
		if (div_done) begin
			case (op_q)
				DIV_LEFT:   qx_q    <= quotient;
				DIV_TOP:    qy_q    <= quotient;
				DIV_RIGHT:  qr_q    <= quotient;
				DIV_BOTTOM: qb_q    <= quotient;
				DIV_COLS:   qc_q    <= quotient;
				DIV_ROWS:   qrows_q <= quotient;
				default: ;
			endcase
		end
	end

	assign cols_cap = (qc_q > DVD_W'(MAX_COLUMNS)) ? DVD_W'(MAX_COLUMNS) : qc_q;
	assign rows_cap = (qrows_q > DVD_W'(MAX_ROWS)) ? DVD_W'(MAX_ROWS) : qrows_q;

	assign pt_addr  = grid_addr(qx_q[COL_W-1:0], qy_q[ROW_W-1:0]);
	assign sc_addr  = grid_addr(i_q, j_q);
	assign last_row = (DVD_W'(j_q) + DVD_W'(1) == qb_q);
	assign last_col = (DVD_W'(i_q) + DVD_W'(1) == qr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			i_q <= qx_q[COL_W-1:0];
			j_q <= qy_q[ROW_W-1:0];
		end else if (cmd.scan_step) begin
			if (last_row) begin
				j_q <= qy_q[ROW_W-1:0];
				i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	assign mem_we = cmd.clr_wr | cmd.mem_wr;
	assign waddr  = cmd.clr_wr ? clr_q : pt_addr;
	assign wdata  = cmd.clr_wr ? code_t'(0) : CODE_BITS'(in_q.write_code);
	assign raddr  = cmd.scan_rd ? sc_addr : pt_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.mem_rd | cmd.scan_rd) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_OK:   res_q <= '{status: 1'b0, tile_code: 16'd0};
				RES_BAD:  res_q <= '{status: 1'b1, tile_code: 16'd0};
				RES_DATA: res_q <= '{status: 1'b0, tile_code: 16'(rdata_q)};
				default:  res_q <= '{status: 1'b0, tile_code: 16'd0};
			endcase
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign stat.func      = in_q.func;
	assign stat.neg       = in_q.x_pos[19] | in_q.y_pos[19];
	assign stat.pt_bad    = (15'(in_q.x_pos[18:4]) >= 15'(mw_q))
		|| (15'(in_q.y_pos[18:4]) >= 15'(mh_q))
		|| (qx_q >= DVD_W'(MAX_COLUMNS)) || (qy_q >= DVD_W'(MAX_ROWS));
	assign stat.q_bad     = (qr_q > cols_cap) || (qb_q > rows_cap);
	assign stat.q_empty   = (qx_q >= qr_q) || (qy_q >= qb_q);
	assign stat.div_done  = div_done;
	assign stat.clr_last  = (clr_q == GRID_W'(GRID_SIZE - 1));
	assign stat.rd_nz     = (rdata_q != '0);
	assign stat.scan_last = last_row & last_col;

	assign out_word = out_q;

endmodule

`default_nettype wire

[hdl/tsrq_ctrl.sv]
// ----------------------------------------------------------------------------
// tsrq_ctrl
// Controller: clearing pass, division sequence, memory access and scan.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrq_ctrl
	import tsrq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  wire logic  out_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EVAL,
		ST_MEM_RD,
		ST_MEM_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DONE
	} state_t;

	state_t  state_q, state_nxt;
	div_op_t op_q, op_nxt;
	logic    out_valid_q;

	always_comb begin
		state_nxt = state_q;
		op_nxt    = op_q;
		cmd       = '0;
		cmd.div_op  = op_q;
		cmd.res_sel = RES_OK;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.func != FUNC_WRITE && stat.func != FUNC_READ
						&& stat.func != FUNC_QUERY) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_OK;
					state_nxt    = ST_DONE;
				end else if (stat.neg) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_BAD;
					state_nxt    = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DIV_LEFT;
					op_nxt        = DIV_LEFT;
					state_nxt     = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					if (op_q == DIV_ROWS || (op_q == DIV_TOP && stat.func != FUNC_QUERY)) begin
						state_nxt = ST_EVAL;
					end else begin
						case (op_q)
							DIV_LEFT:   op_nxt = DIV_TOP;
							DIV_TOP:    op_nxt = DIV_RIGHT;
							DIV_RIGHT:  op_nxt = DIV_BOTTOM;
							DIV_BOTTOM: op_nxt = DIV_COLS;
							default:    op_nxt = DIV_ROWS;
						endcase
						cmd.div_start = 1'b1;
						cmd.div_op    = op_nxt;
					end
				end
			end
			ST_EVAL: begin
				if (stat.func == FUNC_QUERY) begin
					if (stat.q_bad) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_BAD;
						state_nxt    = ST_DONE;
					end else if (stat.q_empty) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_OK;
						state_nxt    = ST_DONE;
					end else begin
						cmd.scan_init = 1'b1;
						state_nxt     = ST_SCAN_RD;
					end
				end else if (stat.pt_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_BAD;
					state_nxt    = ST_DONE;
				end else if (stat.func == FUNC_WRITE) begin
					cmd.mem_wr   = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_OK;
					state_nxt    = ST_DONE;
				end else begin
					state_nxt = ST_MEM_RD;
				end
			end
			ST_MEM_RD: begin
				cmd.mem_rd = 1'b1;
				state_nxt  = ST_MEM_CHK;
			end
			ST_MEM_CHK: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_DATA;
				state_nxt    = ST_DONE;
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_nxt   = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (stat.rd_nz) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_DATA;
					state_nxt    = ST_DONE;
				end else if (stat.scan_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_OK;
					state_nxt    = ST_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					state_nxt     = ST_SCAN_RD;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= DIV_LEFT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			op_q    <= op_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[hdl/tilemap_store_region_query.sv]
// ----------------------------------------------------------------------------
// tilemap_store_region_query
// Tile map store with point write and read and a rectangle region query.
// ----------------------------------------------------------------------------
// After reset the store is cleared one entry a cycle, all 4096 entries,
// during which no word is accepted. Words are handled one at a time. Every
// pixel to tile conversion goes through one shared divider, and the region
// query scan reads the tile store once per tile visited. Func 3 and negative
// coordinates are answered without the divider. A finished result waits in
// the output register until taken.
`default_nettype none

module tilemap_store_region_query
	import tsrq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_word_t              in_word,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_word_t                  out_word,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	tsrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tsrq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.stat      (stat),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

[hdl/tsrq_checker.sv]
// ----------------------------------------------------------------------------
// tsrq_port_checks
// Port level checks of the tile map store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrq_port_checks
	import tsrq_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_word_t out_word
);

	// A stalled result word is held.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result word changed");

	// A word outside the map never carries a tile code.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status |-> out_word.tile_code == 16'd0)
		else $error("out of range result with nonzero code");

	// One word at a time: the input is stalled just after an accept.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// A new result only appears after the block has been busy.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

endmodule

bind tilemap_store_region_query tsrq_port_checks u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

`default_nettype wire
